### hdl/pcc_pkg.sv
// shared types, constants and helpers of the polygon convexity check
`default_nettype none

package pcc_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int NUM_TURNS  = 3;

  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] CNT_ZERO = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_SAT  = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef enum logic [1:0] {
    STATUS_CONVEX  = 2'd0,
    STATUS_CONCAVE = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_POS  = 2'd1,
    TURN_NEG  = 2'd2
  } turn_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
  } vec_t;

  // one queue entry: up to three turns in order, plus closing info
  typedef struct packed {
    logic [NUM_TURNS-1:0] tv;
    vec_t [NUM_TURNS-1:0] e1;
    vec_t [NUM_TURNS-1:0] e2;
    logic                 last;
    logic                 short_poly;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic vec_t edge_of(point_t a, point_t b);
    vec_t v;
    v.dx = diff_t'(b.x) - diff_t'(a.x);
    v.dy = diff_t'(b.y) - diff_t'(a.y);
    return v;
  endfunction

  function automatic turn_e turn_code(prod_t pa, prod_t pb);
    cross_t d;
    turn_e  t;
    d = cross_t'(pa) - cross_t'(pb);
    if (d[CROSS_BITS-1]) begin
      t = TURN_NEG;
    end else if (d == '0) begin
      t = TURN_NONE;
    end else begin
      t = TURN_POS;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/pcc_front.sv
// front end: vertex history, edge vectors and turn jobs
`default_nettype none

module pcc_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire pcc_pkg::coord_t     coord_x_i,
  input  wire pcc_pkg::coord_t     coord_y_i,
  input  wire                      last_vertex_i,
  input  wire pcc_pkg::fifo_stat_t fifo_stat_i,
  output pcc_pkg::push_t           push_o
);

  pcc_pkg::point_t first_q, second_q, prev_q, older_q;
  pcc_pkg::point_t first_d, second_d, prev_d, older_d;
  logic [1:0]      count_q, count_d;
  pcc_pkg::point_t p;
  logic            accept;
  logic            has_turn;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign p.x        = coord_x_i;
  assign p.y        = coord_y_i;
  assign has_turn   = (count_q != pcc_pkg::CNT_ZERO) && (count_q != pcc_pkg::CNT_ONE);

  always_comb begin
    push_o.job.tv         = '0;
    push_o.job.last       = last_vertex_i;
    push_o.job.short_poly = last_vertex_i && !has_turn;
    // turn at the previous vertex
    push_o.job.tv[0] = has_turn;
    push_o.job.e1[0] = pcc_pkg::edge_of(older_q, prev_q);
    push_o.job.e2[0] = pcc_pkg::edge_of(prev_q, p);
    // closing turn at this vertex
    push_o.job.tv[1] = has_turn && last_vertex_i;
    push_o.job.e1[1] = pcc_pkg::edge_of(prev_q, p);
    push_o.job.e2[1] = pcc_pkg::edge_of(p, first_q);
    // closing turn at the first vertex
    push_o.job.tv[2] = has_turn && last_vertex_i;
    push_o.job.e1[2] = pcc_pkg::edge_of(p, first_q);
    push_o.job.e2[2] = pcc_pkg::edge_of(first_q, second_q);
    push_o.valid     = accept && (has_turn || last_vertex_i);
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    prev_d   = prev_q;
    older_d  = older_q;
    count_d  = count_q;
    if (accept) begin
      if (last_vertex_i) begin
        count_d = pcc_pkg::CNT_ZERO;
      end else begin
        if (count_q == pcc_pkg::CNT_ZERO) begin
          first_d = p;
        end
        if (count_q == pcc_pkg::CNT_ONE) begin
          second_d = p;
        end
        older_d = prev_q;
        prev_d  = p;
        if (count_q != pcc_pkg::CNT_SAT) begin
          count_d = count_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pcc_pkg::CNT_ZERO;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    prev_q   <= prev_d;
    older_q  <= older_d;
  end

endmodule

`default_nettype wire

### hdl/pcc_fifo.sv
// short job queue between front and back
`default_nettype none

module pcc_fifo (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire pcc_pkg::push_t      push_i,
  input  wire                      pop_i,
  output pcc_pkg::job_t            head_o,
  output pcc_pkg::fifo_stat_t      stat_o
);

  pcc_pkg::job_t                       mem [pcc_pkg::FIFO_DEPTH];
  logic [pcc_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [pcc_pkg::FIFO_CNT_BITS-1:0]   cnt_q;
  logic                                do_push, do_pop;

  function automatic logic [pcc_pkg::FIFO_PTR_BITS-1:0] ptr_inc(
      logic [pcc_pkg::FIFO_PTR_BITS-1:0] ptr);
    logic [pcc_pkg::FIFO_PTR_BITS-1:0] r;
    if (ptr == pcc_pkg::FIFO_PTR_BITS'(pcc_pkg::FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = ptr + 1'b1;
    end
    return r;
  endfunction

  assign stat_o.full  = (cnt_q == pcc_pkg::FIFO_CNT_BITS'(pcc_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + pcc_pkg::FIFO_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - pcc_pkg::FIFO_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

`default_nettype wire

### hdl/pcc_back.sv
// back end: cross products, sign tracking and result register
`default_nettype none

module pcc_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire pcc_pkg::job_t       head_i,
  input  wire pcc_pkg::fifo_stat_t fifo_stat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic [1:0]               status_o
);

  logic                           s1_valid_q;
  logic [pcc_pkg::NUM_TURNS-1:0]  s1_tv_q;
  pcc_pkg::prod_t                 s1_pa_q [pcc_pkg::NUM_TURNS];
  pcc_pkg::prod_t                 s1_pb_q [pcc_pkg::NUM_TURNS];
  logic                           s1_last_q, s1_short_q;

  pcc_pkg::turn_e                 sign_q, sign_d;
  logic                           concave_q, concave_d;
  logic                           out_valid_q, out_valid_d;
  pcc_pkg::status_e               status_q, status_d;

  logic                           out_free, s1_adv, s1_take;
  pcc_pkg::turn_e                 t;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && (!s1_last_q || out_free);
  assign s1_take  = !s1_valid_q || s1_adv;
  assign pop_o    = s1_take && !fifo_stat_i.empty;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // apply the three turns in order, then close out on a last vertex
  always_comb begin
    sign_d      = sign_q;
    concave_d   = concave_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    t           = pcc_pkg::TURN_NONE;
    if (s1_adv) begin
      for (int i = 0; i < pcc_pkg::NUM_TURNS; i++) begin
        t = s1_tv_q[i] ? pcc_pkg::turn_code(s1_pa_q[i], s1_pb_q[i]) : pcc_pkg::TURN_NONE;
        if (t != pcc_pkg::TURN_NONE) begin
          if (sign_d != pcc_pkg::TURN_NONE && sign_d != t) begin
            concave_d = 1'b1;
          end
          sign_d = t;
        end
      end
      if (s1_last_q) begin
        out_valid_d = 1'b1;
        if (s1_short_q) begin
          status_d = pcc_pkg::STATUS_SHORT;
        end else if (concave_d) begin
          status_d = pcc_pkg::STATUS_CONCAVE;
        end else begin
          status_d = pcc_pkg::STATUS_CONVEX;
        end
        sign_d    = pcc_pkg::TURN_NONE;
        concave_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sign_q      <= pcc_pkg::TURN_NONE;
      concave_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_q <= !fifo_stat_i.empty;
      end
      sign_q      <= sign_d;
      concave_q   <= concave_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (pop_o) begin
      s1_tv_q    <= head_i.tv;
      s1_last_q  <= head_i.last;
      s1_short_q <= head_i.short_poly;
      for (int i = 0; i < pcc_pkg::NUM_TURNS; i++) begin
        s1_pa_q[i] <= pcc_pkg::prod_t'(head_i.e1[i].dx) * pcc_pkg::prod_t'(head_i.e2[i].dy);
        s1_pb_q[i] <= pcc_pkg::prod_t'(head_i.e1[i].dy) * pcc_pkg::prod_t'(head_i.e2[i].dx);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/polygon_convexity_check_core.sv
// top level of the polygon convexity check
//
//  channel   direction  handshake               beat payload
//  vertex    in         in_valid_i/in_ready_o   coord_x_i, coord_y_i, last_vertex_i
//  result    out        out_valid_o/out_ready_i status_o
//
// one vertex beat per cycle; the front end takes a vertex whenever the job queue has room
// result valid once the closing job has passed the queue, the product stage and the result reg
// the product stage (six signed multipliers) sets the clock, one job a cycle when not held
// asynchronous active-low reset clears vertex count, queue, sign tracking and result valid
// a stalled result holds the back end only when the next job closes another polygon,
// other jobs keep draining, and the queue lets the front end run on meanwhile
`default_nettype none

module polygon_convexity_check_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire pcc_pkg::coord_t coord_x_i,
  input  wire pcc_pkg::coord_t coord_y_i,
  input  wire                  last_vertex_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [1:0]           status_o
);

  // jobs from front end into the queue
  pcc_pkg::push_t      push;
  // queue head for the back end, occupancy seen by both ends
  pcc_pkg::job_t       head;
  pcc_pkg::fifo_stat_t fifo_stat;
  logic                pop;

  // front: keeps first, second, previous and older vertex, forms edge vectors
  pcc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .last_vertex_i (last_vertex_i),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push)
  );

  // queue decouples vertex intake from the multiplier stage
  pcc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fifo_stat)
  );

  // back: cross products, sign of last nonzero turn, sticky concave flag
  pcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

### hdl/pcc_checker.sv
// port-level checks of the convexity core, bound to the top level
`default_nettype none

module pcc_port_checks (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_o,
  input wire pcc_pkg::coord_t coord_x_i,
  input wire pcc_pkg::coord_t coord_y_i,
  input wire                  last_vertex_i,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input wire [1:0]            status_o
);

  localparam int PEND_MAX = pcc_pkg::FIFO_DEPTH + 2;

  // polygons closed at the input but not yet delivered
  logic [2:0] pend_q;
  logic       in_last, out_beat;

  assign in_last  = in_valid_i && in_ready_o && last_vertex_i;
  assign out_beat = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_last && !out_beat) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_beat && !in_last) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without a closed polygon");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'(PEND_MAX))
    else $error("more polygons in flight than the pipeline holds");

  logic unused_ok;
  assign unused_ok = ^{coord_x_i, coord_y_i};

endmodule

bind polygon_convexity_check_core pcc_port_checks u_pcc_checker (.*);

`default_nettype wire
